// ----- rtl/core/lcg_random_permutation_generator_core_macros.svh -----
// Assertion macros for the permutation generator core.
// Used by the top level only; assertions are dropped when SYNTHESIS is defined.
`ifndef LCG_RANDOM_PERMUTATION_GENERATOR_CORE_MACROS_SVH
`define LCG_RANDOM_PERMUTATION_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LRPG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lrpg assertion failed");
`define LRPG_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("lrpg forbidden condition seen");
`else
`define LRPG_ASSERT(label, prop)
`define LRPG_ASSERT_NEVER(label, expr)
`endif

`endif

// ----- rtl/core/lrpg_pkg.sv -----
// Shared constants and types of the permutation generator core.
// No dependencies; imported by the controller, datapath and top level.
package lrpg_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  localparam int unsigned GEN_W      = 64;
  localparam int unsigned SEED_W     = 31;
  localparam int unsigned LCG_MUL_W  = 35;
  localparam logic [LCG_MUL_W-1:0] LCG_MUL = 35'h5_DEEC_E66D;
  localparam logic [GEN_W-1:0] LCG_ADD  = 64'd11;
  // The generator step clears bit 49 only.
  localparam logic [GEN_W-1:0] GEN_MASK = ~(64'd2 << 48);
  localparam int unsigned DRAW_SHIFT = 16;
  localparam int unsigned DRAW_W     = GEN_W - DRAW_SHIFT;
  localparam int unsigned DIV_CNT_W  = $clog2(DRAW_W);

  localparam int unsigned DIGIT_W    = 16;
  localparam int unsigned MUL_STEPS  = GEN_W / DIGIT_W;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_STEPS);
  localparam int unsigned PROD_W     = DIGIT_W + LCG_MUL_W;

  localparam logic [1:0] CMD_APPEND  = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic capture;
    logic restart;
    logic mul_start;
    logic mul_step;
    logic gen_load;
    logic div_step;
    logic mem_rd;
    logic wr_slot_n;
    logic wr_slot_j;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       idx_ok;
    logic       mul_last;
    logic       div_last;
  } dp_status_t;

endpackage

// ----- rtl/core/lrpg_ctrl.sv -----
// Controller state machine of the permutation generator core.
// Depends on lrpg_pkg; drives the datapath command struct.
module lrpg_ctrl import lrpg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_GEN,
    S_DIV,
    S_RD,
    S_WR_MOVE,
    S_WR_NEW,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESULT;
        case (status_i.op)
          CMD_APPEND: begin
            if (!status_i.full) begin
              cmd_o.mul_start = 1'b1;
              state_d         = S_MUL;
            end
          end
          CMD_READ: begin
            cmd_o.mem_rd = status_i.idx_ok;
          end
          CMD_RESTART: begin
            cmd_o.restart = 1'b1;
          end
          default: ;
        endcase
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) begin
          state_d = S_GEN;
        end
      end
      S_GEN: begin
        cmd_o.gen_load = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_WR_MOVE;
      end
      S_WR_MOVE: begin
        cmd_o.wr_slot_n = 1'b1;
        state_d         = S_WR_NEW;
      end
      S_WR_NEW: begin
        cmd_o.wr_slot_j = 1'b1;
        state_d         = S_RESULT;
      end
      S_RESULT: begin
        // Hold the finished item until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/lrpg_datapath.sv -----
// Datapath of the permutation generator core: generator, digit-serial multiply,
// bit-serial remainder, entry counter, permutation memory and result register.
// Depends on lrpg_pkg; steered by lrpg_ctrl through dp_cmd_t.
module lrpg_datapath import lrpg_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned AW    = $clog2(MAX_ENTRIES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seed_we_i,
  input  logic [SEED_W-1:0] seed_value_i,
  input  logic [1:0]        cmd_i,
  input  logic [CNT_W-1:0]  entry_index_i,
  output logic [CNT_W-1:0]  value_o,
  output logic [1:0]        status_o,
  input  dp_cmd_t           dp_cmd_i,
  output dp_status_t        dp_status_o
);

  logic [1:0]           op_q;
  logic [CNT_W-1:0]     idx_q;
  logic [SEED_W-1:0]    seed_q;
  logic [GEN_W-1:0]     gen_q, gen_next;
  logic [GEN_W-1:0]     acc_q, acc_d;
  logic [MUL_CNT_W-1:0] mul_cnt_q;
  logic [DIGIT_W-1:0]   digit;
  logic [PROD_W-1:0]    prod;
  logic [DRAW_W-1:0]    sh_q;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W:0]       rem_sh, bound;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [CNT_W-1:0]     count_q, count_n, partner;
  logic [CNT_W-1:0]     mem [MAX_ENTRIES];
  logic [CNT_W-1:0]     rdata_q;
  logic [CNT_W-1:0]     rd_pos, wr_data;
  logic [AW-1:0]        wr_addr;
  logic                 full, idx_ok, append_ok;
  logic [CNT_W-1:0]     res_value;
  logic [1:0]           res_status;
  logic [CNT_W-1:0]     value_q;
  logic [1:0]           status_q;

  assign full      = (count_q == CNT_W'(MAX_ENTRIES));
  assign idx_ok    = (idx_q != '0) && (idx_q <= count_q);
  assign append_ok = (op_q == CMD_APPEND) && !full;
  assign count_n   = count_q + CNT_W'(1);
  assign partner   = rem_q + CNT_W'(1);

  assign dp_status_o.op       = op_q;
  assign dp_status_o.full     = full;
  assign dp_status_o.idx_ok   = idx_ok;
  assign dp_status_o.mul_last = (mul_cnt_q == MUL_CNT_W'(MUL_STEPS - 1));
  assign dp_status_o.div_last = (div_cnt_q == DIV_CNT_W'(DRAW_W - 1));

  // One 16-bit digit of the state times the constant per cycle, low digit first.
  assign digit    = gen_q[{mul_cnt_q, 4'b0000} +: DIGIT_W];
  assign prod     = PROD_W'(digit) * PROD_W'(LCG_MUL);
  assign acc_d    = acc_q + (GEN_W'(prod) << {mul_cnt_q, 4'b0000});
  assign gen_next = (acc_q + LCG_ADD) & GEN_MASK;

  // Restoring remainder step: one quotient bit of (state >> 16) mod n per cycle.
  assign bound  = {1'b0, count_n};
  assign rem_sh = {rem_q, sh_q[DRAW_W-1]};
  always_comb begin
    if (rem_sh >= bound) begin
      rem_d = CNT_W'(rem_sh - bound);
    end else begin
      rem_d = rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= SEED_W'(1);
      gen_q     <= GEN_W'(1);
      count_q   <= '0;
      op_q      <= CMD_APPEND;
      mul_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      if (seed_we_i) begin
        seed_q <= seed_value_i;
        gen_q  <= GEN_W'(seed_value_i);
      end else if (dp_cmd_i.restart) begin
        gen_q <= GEN_W'(seed_q);
      end else if (dp_cmd_i.gen_load) begin
        gen_q <= gen_next;
      end
      if (dp_cmd_i.capture) begin
        op_q <= cmd_i;
      end
      if (dp_cmd_i.restart) begin
        count_q <= '0;
      end else if (dp_cmd_i.out_load && append_ok) begin
        count_q <= count_n;
      end
      if (dp_cmd_i.mul_start) begin
        mul_cnt_q <= '0;
      end else if (dp_cmd_i.mul_step) begin
        mul_cnt_q <= mul_cnt_q + MUL_CNT_W'(1);
      end
      if (dp_cmd_i.gen_load) begin
        div_cnt_q <= '0;
      end else if (dp_cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      idx_q <= entry_index_i;
    end
    if (dp_cmd_i.mul_start) begin
      acc_q <= '0;
    end else if (dp_cmd_i.mul_step) begin
      acc_q <= acc_d;
    end
    if (dp_cmd_i.gen_load) begin
      sh_q  <= gen_next[GEN_W-1:DRAW_SHIFT];
      rem_q <= '0;
    end else if (dp_cmd_i.div_step) begin
      sh_q  <= sh_q << 1;
      rem_q <= rem_d;
    end
  end

  // Positions run from 1, memory addresses from 0.
  assign rd_pos = ((op_q == CMD_READ) ? idx_q : partner) - CNT_W'(1);
  always_comb begin
    if (dp_cmd_i.wr_slot_n) begin
      wr_addr = count_q[AW-1:0];
      wr_data = rdata_q;
    end else begin
      wr_addr = rem_q[AW-1:0];
      wr_data = count_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.wr_slot_n || dp_cmd_i.wr_slot_j) begin
      mem[wr_addr] <= wr_data;
    end
    if (dp_cmd_i.mem_rd) begin
      rdata_q <= mem[rd_pos[AW-1:0]];
    end
  end

  always_comb begin
    res_value  = '0;
    res_status = STATUS_OK;
    case (op_q)
      CMD_APPEND: begin
        if (full) begin
          res_status = STATUS_FULL;
        end else begin
          res_value = partner;
        end
      end
      CMD_READ: begin
        if (idx_ok) begin
          res_value = rdata_q;
        end else begin
          res_status = STATUS_RANGE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.out_load) begin
      value_q  <= res_value;
      status_q <= res_status;
    end
  end

  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

// ----- rtl/core/lcg_random_permutation_generator_core.sv -----
// Random permutation builder: each append places the next number n by the
// inside-out shuffle, drawing a partner j = 1 + ((state >> 16) mod n) from a
// 64-bit linear congruential generator, and returns j; a read returns one
// entry and a restart empties the table and reloads the generator from the
// seed register, which also loads it when written. One item is worked on at
// a time. An append is decoded, multiplies the four 16-bit digits of the
// state, finishes the generator step, runs the bit-serial remainder loop
// over the 48 draw bits that dominates, reads and moves the displaced entry,
// writes n and loads the result register. A read, restart, refused item or
// unused code is decoded and then loads the result register. A new item is
// taken while the previous result still waits in the output register,
// which is the only place the block can stall.
`include "lcg_random_permutation_generator_core_macros.svh"

module lcg_random_permutation_generator_core import lrpg_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seed_we_i,
  input  logic [SEED_W-1:0] seed_value_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [CNT_W-1:0]  entry_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CNT_W-1:0]  value_o,
  output logic [1:0]        status_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  lrpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  lrpg_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_we_i     (seed_we_i),
    .seed_value_i  (seed_value_i),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .value_o       (value_o),
    .status_o      (status_o),
    .dp_cmd_i      (dp_cmd),
    .dp_status_o   (dp_status)
  );

  // Once an item is taken, the block is not ready again in the next cycle.
  `LRPG_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // The partner write always follows the move of the displaced entry.
  `LRPG_ASSERT(a_write_order, dp_cmd.wr_slot_n |=> dp_cmd.wr_slot_j)
  // A finished result never overwrites one that has not been taken.
  `LRPG_ASSERT_NEVER(a_no_overwrite, dp_cmd.out_load && out_valid_o && !out_ready_i)
  // Only defined status codes leave the block.
  `LRPG_ASSERT(a_status_code, out_valid_o |-> (status_o == STATUS_OK ||
      status_o == STATUS_FULL || status_o == STATUS_RANGE))

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for lcg_random_permutation_generator_core.
// Depends on lrpg_pkg for command and status codes and on the core RTL itself;
// results are checked against an in-bench shuffle predictor.
module tb import lrpg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int unsigned IDX_W = 11;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 64;

  typedef struct packed {
    logic [IDX_W-1:0] value;
    logic [1:0]       status;
  } perm_result_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] index;
    logic             fixed;
    logic [IDX_W-1:0] value;
    logic [1:0]       status;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              seed_we_i;
  logic [SEED_W-1:0] seed_value_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        cmd_i;
  logic [IDX_W-1:0]  entry_index_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [IDX_W-1:0]  value_o;
  logic [1:0]        status_o;

  // Shuffle predictor state.
  logic [SEED_W-1:0] seed_reg;
  logic [63:0]       lcg_state;
  int unsigned       perm_count;
  logic [IDX_W-1:0]  perm_slots [1:TABLE_DEPTH];

  perm_result_t expected_results [$];
  perm_result_t oldest;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_cycles;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned n_appends;
  int unsigned n_reads;
  int unsigned n_full;
  int unsigned n_range;

  // Expected values are read off directly only where the answer is obvious:
  // the first append after an empty table always picks partner 1.
  directed_row_t directed_rows [24] = '{
    '{CMD_READ,    11'd1,    1'b1, 11'd0, STATUS_RANGE},
    '{CMD_READ,    11'd0,    1'b1, 11'd0, STATUS_RANGE},
    '{CMD_APPEND,  11'd0,    1'b1, 11'd1, STATUS_OK},
    '{CMD_READ,    11'd1,    1'b1, 11'd1, STATUS_OK},
    '{CMD_READ,    11'd2,    1'b1, 11'd0, STATUS_RANGE},
    '{CMD_READ,    11'd2047, 1'b1, 11'd0, STATUS_RANGE},
    '{CMD_UNUSED,  11'd2047, 1'b1, 11'd0, STATUS_OK},
    '{CMD_APPEND,  11'd2047, 1'b0, 11'd0, STATUS_OK},
    '{CMD_APPEND,  11'd1024, 1'b0, 11'd0, STATUS_OK},
    '{CMD_APPEND,  11'd0,    1'b0, 11'd0, STATUS_OK},
    '{CMD_APPEND,  11'd0,    1'b0, 11'd0, STATUS_OK},
    '{CMD_READ,    11'd1,    1'b0, 11'd0, STATUS_OK},
    '{CMD_READ,    11'd2,    1'b0, 11'd0, STATUS_OK},
    '{CMD_READ,    11'd3,    1'b0, 11'd0, STATUS_OK},
    '{CMD_READ,    11'd4,    1'b0, 11'd0, STATUS_OK},
    '{CMD_READ,    11'd5,    1'b0, 11'd0, STATUS_OK},
    '{CMD_READ,    11'd6,    1'b1, 11'd0, STATUS_RANGE},
    '{CMD_READ,    11'd1024, 1'b1, 11'd0, STATUS_RANGE},
    '{CMD_RESTART, 11'd2047, 1'b1, 11'd0, STATUS_OK},
    '{CMD_READ,    11'd1,    1'b1, 11'd0, STATUS_RANGE},
    '{CMD_APPEND,  11'd0,    1'b1, 11'd1, STATUS_OK},
    '{CMD_APPEND,  11'd1,    1'b0, 11'd0, STATUS_OK},
    '{CMD_READ,    11'd2,    1'b0, 11'd0, STATUS_OK},
    '{CMD_UNUSED,  11'd0,    1'b1, 11'd0, STATUS_OK}
  };

  lcg_random_permutation_generator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_we_i     (seed_we_i),
    .seed_value_i  (seed_value_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one command to the predicted table and returns its result.
  function automatic perm_result_t apply_command(input logic [1:0] cmd,
                                                 input logic [IDX_W-1:0] index);
    perm_result_t res;
    int unsigned  n;
    int unsigned  j;
    res = '0;
    res.status = STATUS_OK;
    case (cmd)
      CMD_APPEND: begin
        if (perm_count >= TABLE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          n = perm_count + 1;
          lcg_state = (lcg_state * 64'(LCG_MUL) + LCG_ADD) & GEN_MASK;
          j = 1 + int'((lcg_state >> DRAW_SHIFT) % 64'(n));
          perm_slots[n] = perm_slots[j];
          perm_slots[j] = IDX_W'(n);
          perm_count = n;
          res.value = IDX_W'(j);
        end
      end
      CMD_READ: begin
        if (index == '0 || index > perm_count) begin
          res.status = STATUS_RANGE;
        end else begin
          res.value = perm_slots[index];
        end
      end
      CMD_RESTART: begin
        perm_count = 0;
        lcg_state = {33'd0, seed_reg};
      end
      default: ;
    endcase
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_item(input logic [1:0] cmd, input logic [IDX_W-1:0] index,
                            input logic fixed, input logic [IDX_W-1:0] fixed_value,
                            input logic [1:0] fixed_status);
    perm_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    entry_index_i <= index;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_command(cmd, index);
    if (cmd == CMD_APPEND) n_appends++;
    if (cmd == CMD_READ) n_reads++;
    if (predicted.status == STATUS_FULL) n_full++;
    if (predicted.status == STATUS_RANGE) n_range++;
    if (fixed) begin
      predicted.value  = fixed_value;
      predicted.status = fixed_status;
    end
    expected_results = {expected_results, predicted};
    @(negedge clk_i);
  endtask

  task automatic issue_random(input bit filling);
    int unsigned      pick;
    logic [1:0]       cmd;
    logic [IDX_W-1:0] index;
    pick = $urandom_range(99);
    index = IDX_W'($urandom);
    if (filling) begin
      cmd = (pick < 97) ? CMD_APPEND : (pick < 99) ? CMD_READ : CMD_UNUSED;
    end else begin
      cmd = (pick < 50) ? CMD_APPEND : (pick < 85) ? CMD_READ :
            (pick < 94) ? CMD_RESTART : CMD_UNUSED;
    end
    // Most reads land on a filled slot; the rest probe any index at all.
    if (cmd == CMD_READ && perm_count != 0 && $urandom_range(3) != 0) begin
      index = IDX_W'($urandom_range(perm_count, 1));
    end
    issue_item(cmd, index, 1'b0, '0, STATUS_OK);
  endtask

  // The seed may only be written while the core has nothing in flight.
  task automatic load_seed(input logic [SEED_W-1:0] seed);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    seed_we_i    <= 1'b1;
    seed_value_i <= seed;
    @(negedge clk_i);
    seed_we_i <= 1'b0;
    seed_reg = seed;
    lcg_state = {33'd0, seed};
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value %0d status %0d", $time, value_o, status_o);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        if (value_o !== oldest.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d",
                   $time, oldest.value, value_o);
          mismatches++;
        end
        if (status_o !== oldest.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, oldest.status, status_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, stall_cycles, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned full_mark;
    rst_ni        = 1'b0;
    seed_we_i     = 1'b0;
    seed_value_i  = '0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_APPEND;
    entry_index_i = '0;
    send_idle_pct = 30;
    recv_idle_pct = 85;
    stall_cycles  = 0;
    mismatches    = 0;
    results_checked = 0;
    n_appends = 0;
    n_reads   = 0;
    n_full    = 0;
    n_range   = 0;
    seed_reg   = 31'd1;
    lcg_state  = 64'd1;
    perm_count = 0;
    foreach (perm_slots[i]) perm_slots[i] = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows run on the seed that reset leaves behind.
    foreach (directed_rows[i]) begin
      issue_item(directed_rows[i].cmd, directed_rows[i].index, directed_rows[i].fixed,
                 directed_rows[i].value, directed_rows[i].status);
    end

    // Reloading the generator without a restart keeps the table as it is.
    load_seed(31'h7FFF_FFFF);
    repeat (20) issue_random(1'b0);

    send_idle_pct = 85;
    recv_idle_pct = 30;
    load_seed(31'd0);
    repeat (20) issue_random(1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_seed(SEED_W'($urandom_range(32'h7FFF_FFFF, 1)));
    issue_item(CMD_RESTART, IDX_W'($urandom), 1'b0, '0, STATUS_OK);
    // Fill the whole table and keep appending until it has refused a few times.
    full_mark = n_full;
    while (n_full - full_mark < 4) issue_random(1'b1);
    repeat (10) issue_random(1'b1);

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d appends and %0d reads over three handshake mixes and four seeds.",
             n_appends, n_reads);
    $display("Checked %0d results: %0d table-full, %0d out-of-range, %0d mismatches.",
             results_checked, n_full, n_range, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
